// ===== hdl/mrtu_pkg.sv =====
// Shared types, constants and CRC helper for the RTU slave frame handler.
// No dependencies.
package mrtu_pkg;

    localparam int REG_COUNT_DEF = 16;
    localparam int MAX_FRAME_DEF = 64;

    // Function codes
    localparam logic [7:0] FN_READ  = 8'h03;
    localparam logic [7:0] FN_WR1   = 8'h06;
    localparam logic [7:0] FN_WRM   = 8'h10;
    localparam logic [7:0] EXC_FLAG = 8'h80;
    localparam logic [7:0] EXC_FUNC = 8'h01;
    localparam logic [7:0] EXC_ADDR = 8'h02;

    // Command kinds between front and back
    localparam logic [1:0] K_READ = 2'd0;
    localparam logic [1:0] K_WR1  = 2'd1;
    localparam logic [1:0] K_WRM  = 2'd2;
    localparam logic [1:0] K_EXC  = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_tx_item;

    // Classified request: header bytes 0..6 (zero past frame end)
    typedef struct packed {
        logic [1:0]      kind;
        logic [7:0]      code;
        logic [6:0][7:0] req;
        logic [8:0]      len;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    // CRC-16, reflected poly 0xA001, one byte
    function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ===== hdl/mrtu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== hdl/mrtu_front.sv =====
// Front part: takes received bytes, keeps running CRCs and header bytes,
// classifies a frame at its end. Depends on mrtu_pkg.
module mrtu_front #(
    parameter int REG_COUNT = 16,
    parameter int MAX_FRAME = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mrtu_pkg::t_rx_item           i_in_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         i_hold,
    output logic                         o_we,
    output logic [$clog2(MAX_FRAME)-1:0] o_waddr,
    output logic [7:0]                   o_wdata,
    output logic                         o_push,
    output mrtu_pkg::t_cmd               o_cmd
);
    import mrtu_pkg::*;

    localparam int LW = $clog2(MAX_FRAME + 1);
    localparam int AW = $clog2(MAX_FRAME);

    logic [LW-1:0]   r_len;
    logic [15:0]     r_c0, r_c1, r_c2;
    logic [7:0]      r_blast, r_bprev;
    logic [6:0][7:0] r_hdr;
    logic [7:0]      r_addr;

    logic            acc, full, ok, bad;
    logic [6:0][7:0] req;
    logic [15:0]     start, count;
    logic [16:0]     sum;
    logic [15:0]     crc_new;

    assign o_in_ready  = !i_hold;
    assign o_cfg_ready = 1'b1;
    assign acc  = i_in_valid && o_in_ready;
    assign full = (r_len == LW'(MAX_FRAME));

    // Frame store write
    assign o_we    = acc && !i_in_data.action;
    assign o_waddr = full ? AW'(MAX_FRAME - 1) : r_len[AW-1:0];
    assign o_wdata = i_in_data.rx_byte;
    assign crc_new = crc_upd(full ? r_c1 : r_c0, i_in_data.rx_byte);

    // Header bytes, zero past frame end
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            req[i] = (LW'(i) < r_len) ? r_hdr[i] : 8'h00;
        end
    end

    // Classification at frame end
    assign start = {req[2], req[3]};
    assign count = {req[4], req[5]};
    assign sum   = {1'b0, start} + {1'b0, count};
    assign bad   = (start >= 16'(REG_COUNT)) || (count > 16'(REG_COUNT))
                   || (sum > 17'(REG_COUNT));
    assign ok    = (r_len >= LW'(4)) && (r_hdr[0] == r_addr)
                   && (r_c2 == {r_blast, r_bprev});
    assign o_push = acc && i_in_data.action && ok;

    always_comb begin
        o_cmd      = '0;
        o_cmd.req  = req;
        o_cmd.len  = 9'(r_len);
        case (req[1])
            FN_READ: begin
                o_cmd.kind = bad ? K_EXC : K_READ;
                o_cmd.code = EXC_ADDR;
            end
            FN_WR1: begin
                o_cmd.kind = (start >= 16'(REG_COUNT)) ? K_EXC : K_WR1;
                o_cmd.code = EXC_ADDR;
            end
            FN_WRM: begin
                o_cmd.kind = bad ? K_EXC : K_WRM;
                o_cmd.code = EXC_ADDR;
            end
            default: begin
                o_cmd.kind = K_EXC;
                o_cmd.code = EXC_FUNC;
            end
        endcase
    end

    // Length, CRC history, header capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_c0   <= 16'hFFFF;
            r_c1   <= 16'hFFFF;
            r_c2   <= 16'hFFFF;
            r_addr <= 8'h01;
        end else begin
            if (i_cfg_valid) begin
                r_addr <= i_cfg_data;
            end
            if (acc && i_in_data.action) begin
                r_len <= '0;
                r_c0  <= 16'hFFFF;
                r_c1  <= 16'hFFFF;
                r_c2  <= 16'hFFFF;
            end else if (acc) begin
                r_c0 <= crc_new;
                if (!full) begin
                    r_len <= r_len + LW'(1);
                    r_c1  <= r_c0;
                    r_c2  <= r_c1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !i_in_data.action) begin
            r_blast <= i_in_data.rx_byte;
            if (!full) begin
                r_bprev <= r_blast;
            end
            for (int i = 0; i < 7; i++) begin
                if (!full && r_len == LW'(i)) begin
                    r_hdr[i] <= i_in_data.rx_byte;
                end
            end
        end
    end
endmodule

// ===== hdl/mrtu_cmdq.sv =====
// Two-entry command queue between front and back.
// Depends on mrtu_pkg.
module mrtu_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrtu_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output mrtu_pkg::t_cmd o_cmd
);
    import mrtu_pkg::*;

    t_cmd r_ent [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && r_cnt != 2'd2) begin
                r_wp <= !r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && r_cnt != 2'd2) ? 1 : 0)
                           - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && r_cnt != 2'd2) begin
            r_ent[r_wp] <= i_cmd;
        end
    end
endmodule

// ===== hdl/mrtu_back.sv =====
// Back part: holding register file, multi-write sweep, reply builder with
// CRC and output register. Depends on mrtu_pkg.
module mrtu_back #(
    parameter int REG_COUNT = 16,
    parameter int MAX_FRAME = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  mrtu_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output logic [$clog2(MAX_FRAME)-1:0] o_raddr,
    input  logic [7:0]                   i_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mrtu_pkg::t_tx_item           o_out_data,
    output mrtu_pkg::t_back_stat         o_stat
);
    import mrtu_pkg::*;

    localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int JW = $clog2(2 * REG_COUNT + 6);
    localparam int AW = $clog2(MAX_FRAME);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WMRQ = 2'd1;
    localparam logic [1:0] S_WMWR = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]  r_st;
    t_cmd        r_cmd;
    logic [15:0] r_file [REG_COUNT];
    logic [7:0]  r_k;
    logic [9:0]  r_pos;
    logic        r_zero;
    logic [JW-1:0] r_j, r_blen;
    logic [IW-1:0] r_rp;
    logic        r_half;
    logic [15:0] r_crc;
    logic        r_ov;
    t_tx_item    r_out;

    logic [9:0]  pos;
    logic [8:0]  rd_idx;
    logic        slot;
    logic [7:0]  body, ob;
    logic        last;
    logic [15:0] rword;

    assign o_stat.busy = (r_st != S_IDLE);
    assign o_pop       = (r_st == S_IDLE) && i_q_valid;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign slot        = !r_ov || i_out_ready;

    // Multi-write byte position and frame index
    assign pos     = {1'b0, r_cmd.req[3], 1'b0} + 10'(r_k);
    assign rd_idx  = 9'd7 + 9'(r_k);
    assign o_raddr = rd_idx[AW-1:0];

    // Reply byte selection
    assign rword = r_file[r_rp];
    always_comb begin
        body = 8'h00;
        if (r_j == '0) begin
            body = r_cmd.req[0];
        end else begin
            case (r_cmd.kind)
                K_EXC: begin
                    body = (r_j == JW'(1)) ? r_cmd.req[1] + EXC_FLAG : r_cmd.code;
                end
                K_READ: begin
                    if (r_j == JW'(1)) begin
                        body = FN_READ;
                    end else if (r_j == JW'(2)) begin
                        body = {r_cmd.req[5][6:0], 1'b0};
                    end else begin
                        body = r_half ? rword[7:0] : rword[15:8];
                    end
                end
                default: begin
                    body = r_cmd.req[r_j[2:0]];
                end
            endcase
        end
    end
    assign last = (r_j == r_blen + JW'(1));
    assign ob   = (r_j == r_blen) ? r_crc[7:0] : (last ? r_crc[15:8] : body);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_file[i] <= 16'h0000;
            end
        end else begin
            // While emitting, the output register is reloaded whenever it frees up
            if (r_ov && i_out_ready && r_st != S_EMIT) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd  <= i_cmd;
                        r_k    <= 8'd0;
                        r_j    <= '0;
                        r_crc  <= 16'hFFFF;
                        r_half <= 1'b0;
                        r_rp   <= i_cmd.req[3][IW-1:0];
                        r_blen <= (i_cmd.kind == K_READ) ?
                                  JW'(3) + JW'({i_cmd.req[5], 1'b0}) :
                                  ((i_cmd.kind == K_EXC) ? JW'(3) : JW'(6));
                        if (i_cmd.kind == K_WR1) begin
                            r_file[i_cmd.req[3][IW-1:0]] <= {i_cmd.req[4], i_cmd.req[5]};
                        end
                        r_st <= (i_cmd.kind == K_WRM) ? S_WMRQ : S_EMIT;
                    end
                end
                S_WMRQ: begin
                    if (r_k == r_cmd.req[6] || pos >= 10'(2 * REG_COUNT)) begin
                        r_st <= S_EMIT;
                    end else begin
                        r_pos  <= pos;
                        r_zero <= (rd_idx >= r_cmd.len);
                        r_st   <= S_WMWR;
                    end
                end
                S_WMWR: begin
                    if (r_pos[0]) begin
                        r_file[r_pos[IW:1]][7:0] <= r_zero ? 8'h00 : i_rdata;
                    end else begin
                        r_file[r_pos[IW:1]][15:8] <= r_zero ? 8'h00 : i_rdata;
                    end
                    r_k  <= r_k + 8'd1;
                    r_st <= S_WMRQ;
                end
                S_EMIT: begin
                    if (slot) begin
                        r_ov          <= 1'b1;
                        r_out.tx_byte <= ob;
                        r_out.tx_last <= last;
                        r_j           <= r_j + JW'(1);
                        if (r_j < r_blen) begin
                            r_crc <= crc_upd(r_crc, ob);
                        end
                        if (r_cmd.kind == K_READ && r_j >= JW'(3)) begin
                            r_half <= !r_half;
                            if (r_half) begin
                                r_rp <= r_rp + IW'(1);
                            end
                        end
                        if (last) begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/modbus_rtu_slave_frame_handler_unit.sv =====
// RTU slave frame handler top level: front, command queue, back, frame RAM.
// Received byte: no result. End of an accepted frame: queue, then command register,
// then first reply byte registered, then 1 byte per cycle while the receiver takes
// them; a multi-write first loops S_WMRQ/S_WMWR per data byte (one RAM read port).
// Input held from end of an accepted frame until the last reply byte is registered.
// Reset (synchronous, active low) clears lengths, queue, register file, address=1.
module modbus_rtu_slave_frame_handler_unit #(
    parameter int REG_COUNT = mrtu_pkg::REG_COUNT_DEF,
    parameter int MAX_FRAME = mrtu_pkg::MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mrtu_pkg::t_rx_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mrtu_pkg::t_tx_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import mrtu_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);

    logic          we, push, pop, q_valid;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    t_cmd          f_cmd, q_cmd;
    t_back_stat    stat;

    mrtu_front #(.REG_COUNT(REG_COUNT), .MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_data,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_hold(q_valid || stat.busy),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_push(push), .o_cmd(f_cmd)
    );

    mrtu_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    mrtu_cmdq u_q (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(f_cmd),
        .i_pop(pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    mrtu_back #(.REG_COUNT(REG_COUNT), .MAX_FRAME(MAX_FRAME)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_raddr(raddr), .i_rdata(rdata),
        .o_out_valid, .i_out_ready, .o_out_data, .o_stat(stat)
    );
endmodule

// ===== hdl/mrtu_checker.sv =====
// Port-level checks for the RTU slave frame handler, bound to the top level.
// Depends on mrtu_pkg.
module mrtu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mrtu_pkg::t_rx_item i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mrtu_pkg::t_tx_item o_out_data
);
    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Nothing shown right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A received byte never starts a reply
    a_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.action && !o_out_valid |=> !o_out_valid)
        else $error("reply byte after received byte");

    // While a non-final reply byte is shown, input stays blocked
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.tx_last |-> !o_in_ready)
        else $error("input taken during reply");
endmodule

bind modbus_rtu_slave_frame_handler_unit mrtu_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_data,
    .o_out_valid, .i_out_ready, .o_out_data
);
